FILE: src/rrt_pkg.sv
// Shared codes, field widths and controller/datapath interface types for the remap table.
`timescale 1ns / 1ps

package rrt_pkg;

    // Fixed widths of the stream fields
    localparam int FIELD_W  = 48;
    localparam int OP_W     = 2;
    localparam int HIDX_W   = 5;
    localparam int STAT_W   = 2;
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 56;

    // Operation codes carried in tuser
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_FWD = 2'd1;
    localparam logic [OP_W-1:0] OP_INV = 2'd2;
    localparam logic [OP_W-1:0] OP_CLR = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OVF  = 2'd3;

    // Result selection commanded by the controller
    localparam int RES_W = 3;
    localparam logic [RES_W-1:0] RES_NONE = 3'd0;
    localparam logic [RES_W-1:0] RES_ZERO = 3'd1;
    localparam logic [RES_W-1:0] RES_FULL = 3'd2;
    localparam logic [RES_W-1:0] RES_OVF  = 3'd3;
    localparam logic [RES_W-1:0] RES_MISS = 3'd4;
    localparam logic [RES_W-1:0] RES_HIT  = 3'd5;

    typedef struct packed {
        logic             load_in;
        logic             wr_entry;
        logic             clr_count;
        logic             scan_start;
        logic             scan_next;
        logic             take_hit;
        logic [RES_W-1:0] res_sel;
        logic             load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            ovf;
        logic            scan_end;
        logic            match;
        logic            out_free;
    } t_dp_sts;

endpackage

FILE: src/range_remap_table.sv
// Top level of the range remap table: stream ports, controller and datapath.
// Add and clear answer once decoded; a translate scans entries in order, each entry taking
// a memory read, then a compare, and answers on the first matching entry, or with a
// passthrough once no stored entry is left. A finished result waits until the output is free.
// Throughput: one request in flight; the scan loop through the single table read port sets it.
// Reset (synchronous, active low) empties the table and drops any pending result.
`timescale 1ns / 1ps

module range_remap_table #(
    parameter int ENTRIES  = 32,
    parameter int ID_WIDTH = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata, low bit up: dest_start[47:0], source_start[95:48], range_length[143:96],
    // lookup_id[191:144]
    input  logic [rrt_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // tuser: op[1:0]
    input  logic [rrt_pkg::OP_W-1:0]          i_s_axis_tuser,
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata, low bit up: mapped_id[47:0], hit[48], hit_index[53:49], status[55:54]
    output logic [rrt_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    rrt_pkg::t_dp_cmd cmd;
    rrt_pkg::t_dp_sts sts;

    // Controller: takes one request at a time and steps the datapath through it.
    rrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: holds the table and the result register; the result register lets the
    // next request start while a finished result still waits on the output side.
    rrt_dp #(
        .ENTRIES  (ENTRIES),
        .ID_WIDTH (ID_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_s_axis_tdata),
        .i_in_op     (i_s_axis_tuser),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

    // Sequential controller: a request just taken blocks the next one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request taken while previous one still in work");

    // A hit always reports a done status.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[48]) |-> (o_m_axis_tdata[55:54] == rrt_pkg::STAT_DONE))
        else $error("hit reported with a non-done status");

    // Without a hit the entry index reads zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[48]) |-> (o_m_axis_tdata[53:49] == '0))
        else $error("nonzero hit_index without a hit");

    // A passthrough result carries no hit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[55:54] == rrt_pkg::STAT_MISS))
            |-> !o_m_axis_tdata[48])
        else $error("miss status with hit set");

endmodule

FILE: src/rrt_ctrl.sv
// Controller state machine: decode each request, sequence the table scan, hand off the result.
`timescale 1ns / 1ps

module rrt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rrt_pkg::t_dp_sts i_sts,
    output rrt_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_ADD    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_sel = rrt_pkg::RES_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    rrt_pkg::OP_ADD: begin
                        if (i_sts.full) begin
                            o_cmd.res_sel = rrt_pkg::RES_FULL;
                        end else if (i_sts.ovf) begin
                            o_cmd.res_sel = rrt_pkg::RES_OVF;
                        end else begin
                            o_cmd.wr_entry = 1'b1;
                            o_cmd.res_sel  = rrt_pkg::RES_ZERO;
                        end
                        n_state = S_DONE;
                    end
                    rrt_pkg::OP_CLR: begin
                        o_cmd.clr_count = 1'b1;
                        o_cmd.res_sel   = rrt_pkg::RES_ZERO;
                        n_state = S_DONE;
                    end
                    default: begin
                        // preset the passthrough answer, overwritten on a hit
                        o_cmd.res_sel    = rrt_pkg::RES_MISS;
                        o_cmd.scan_start = 1'b1;
                        n_state = S_READ;
                    end
                endcase
            end
            S_READ: begin
                if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.match) begin
                    o_cmd.take_hit = 1'b1;
                    n_state = S_ADD;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = S_READ;
                end
            end
            S_ADD: begin
                o_cmd.res_sel = rrt_pkg::RES_HIT;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/rrt_dp.sv
// Datapath: request registers, range table memory, range compare, offset add, output register.
`timescale 1ns / 1ps

module rrt_dp #(
    parameter int ENTRIES  = 32,
    parameter int ID_WIDTH = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rrt_pkg::t_dp_cmd                  i_cmd,
    output rrt_pkg::t_dp_sts                  o_sts,
    input  logic [rrt_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic [rrt_pkg::OP_W-1:0]          i_in_op,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rrt_pkg::OUT_DATA_W-1:0]    o_out_data
);

    localparam int W     = ID_WIDTH;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW    = rrt_pkg::FIELD_W;

    typedef struct packed {
        logic [W-1:0] src;
        logic [W-1:0] dst;
        logic [W-1:0] span;
    } t_entry;

    t_entry r_mem [ENTRIES];
    t_entry r_ent;

    logic [rrt_pkg::OP_W-1:0] r_op;
    logic [W-1:0]             r_dst;
    logic [W-1:0]             r_src;
    logic [W-1:0]             r_len;
    logic [W-1:0]             r_id;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_idx;
    logic [W-1:0]             r_diff;
    logic [W-1:0]             r_to;

    logic [FW-1:0]                    r_res_mapped;
    logic                             r_res_hit;
    logic [rrt_pkg::HIDX_W-1:0]       r_res_hidx;
    logic [rrt_pkg::STAT_W-1:0]       r_res_status;

    logic                             r_out_valid;
    logic [rrt_pkg::OUT_DATA_W-1:0]   r_out_data;

    logic [W-1:0] len_m1;
    logic         ovf;
    logic [W-1:0] from_base;
    logic [W-1:0] to_base;
    logic [W-1:0] diff;
    logic         match;

    // overflow: source or dest start + len - 1 beyond the id range, i.e. len - 1 > ~start
    assign len_m1 = r_len - W'(1);
    assign ovf    = (r_len != '0) && ((len_m1 > ~r_src) || (len_m1 > ~r_dst));

    assign from_base = (r_op == rrt_pkg::OP_FWD) ? r_ent.src : r_ent.dst;
    assign to_base   = (r_op == rrt_pkg::OP_FWD) ? r_ent.dst : r_ent.src;
    assign diff      = r_id - from_base;
    assign match     = (r_ent.span != '0) && (r_id >= from_base) && (diff < r_ent.span);

    always_comb begin
        o_sts.op       = r_op;
        o_sts.full     = (r_count == CNT_W'(ENTRIES));
        o_sts.ovf      = ovf;
        o_sts.scan_end = (r_idx >= r_count);
        o_sts.match    = match;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_in_op;
            r_dst <= W'(i_in_data[FW-1:0]);
            r_src <= W'(i_in_data[2*FW-1:FW]);
            r_len <= W'(i_in_data[3*FW-1:2*FW]);
            r_id  <= W'(i_in_data[4*FW-1:3*FW]);
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry) begin
            r_mem[r_count[IDX_W-1:0]] <= '{src: r_src, dst: r_dst, span: r_len};
        end
        r_ent <= r_mem[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clr_count) begin
            r_count <= '0;
        end else if (i_cmd.wr_entry) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.scan_next) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.take_hit) begin
            r_diff <= diff;
            r_to   <= to_base;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.res_sel)
            rrt_pkg::RES_ZERO: begin
                r_res_mapped <= '0;
                r_res_hit    <= 1'b0;
                r_res_hidx   <= '0;
                r_res_status <= rrt_pkg::STAT_DONE;
            end
            rrt_pkg::RES_FULL: begin
                r_res_mapped <= '0;
                r_res_hit    <= 1'b0;
                r_res_hidx   <= '0;
                r_res_status <= rrt_pkg::STAT_FULL;
            end
            rrt_pkg::RES_OVF: begin
                r_res_mapped <= '0;
                r_res_hit    <= 1'b0;
                r_res_hidx   <= '0;
                r_res_status <= rrt_pkg::STAT_OVF;
            end
            rrt_pkg::RES_MISS: begin
                r_res_mapped <= FW'(r_id);
                r_res_hit    <= 1'b0;
                r_res_hidx   <= '0;
                r_res_status <= rrt_pkg::STAT_MISS;
            end
            rrt_pkg::RES_HIT: begin
                r_res_mapped <= FW'(r_to + r_diff);
                r_res_hit    <= 1'b1;
                r_res_hidx   <= rrt_pkg::HIDX_W'(r_idx);
                r_res_status <= rrt_pkg::STAT_DONE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {r_res_status, r_res_hidx, r_res_hit, r_res_mapped};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
